// ----- rtl/stereo_width_smoothed_macros.svh -----
// Assertion macros shared by the stereo width checker.
`ifndef STEREO_WIDTH_SMOOTHED_MACROS_SVH
`define STEREO_WIDTH_SMOOTHED_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define SWSM_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define SWSM_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/swsm_pkg.sv -----
// Types and constants of the smoothed stereo width block.
`timescale 1ns / 1ps

package swsm_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int GAIN_W      = 32;
	localparam int COEF_W      = 16;
	localparam int CFG_W       = 16;
	localparam int CFG_IDX_W   = 2;

	localparam int MUL_A_W = GAIN_W + 1;
	localparam int DLR_W   = SAMPLE_BITS + 1;
	localparam int MUL_B_W = (DLR_W > COEF_W + 1) ? DLR_W : COEF_W + 1;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	// scaled side term fits in SAMPLE_BITS + 3 bits, and so do mid +/- side
	localparam int MIX_W   = SAMPLE_BITS + 3;

	localparam logic [CFG_IDX_W-1:0] REG_SIDE_TARGET    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTHING_COEF = CFG_IDX_W'(1);

	localparam logic [CFG_W-1:0]  TARGET_RESET = 16'd16384;
	localparam logic [COEF_W-1:0] COEF_RESET   = 16'd4096;
	localparam logic [CFG_W-1:0]  TARGET_MAX   = 16'd32768;
	localparam logic [GAIN_W-1:0] GAIN_UNITY   = 32'h4000_0000;

	localparam logic signed [PROD_W-1:0] HALF_STEP = PROD_W'(1) << 15;
	localparam logic signed [PROD_W-1:0] HALF_SIDE = PROD_W'(1) << 29;

	localparam logic signed [MUL_A_W-1:0] SNAP_HI = MUL_A_W'(1024);
	localparam logic signed [MUL_A_W-1:0] SNAP_LO = -MUL_A_W'(1024);

	localparam logic signed [SAMPLE_BITS-1:0] SAT_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAT_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_STEP,
		ST_GAIN,
		ST_SIDE,
		ST_MIX
	} state_t;

	typedef struct packed {
		logic en;
		logic side;
	} mul_ctrl_t;

endpackage

// ----- rtl/stereo_width_smoothed.sv -----
// Mid/side stereo width with a gain that eases toward its target frame by frame.
// Each frame of two signed samples is split into mid and side; side is scaled by
// a Q2.30 gain that takes one rounded one-pole step toward side_target (Q2.14,
// clamped to 2.0) per frame, with smoothing_coef as Q0.16 weight. Outputs are
// mid +/- scaled side, rounded half up, saturated, with clipped set on overflow.
// On a frame marked block_end the gain snaps to the target once within 2^-20.
// A frame runs through the step, gain, side and mix states from acceptance to a
// result in the output register; its two products go one after the other through
// a single shared multiplier, with the gain update between them. in_stall is
// high in all states but idle, so a new frame is taken only after the last
// leaves the mix state; the mix state holds, and in_stall with it, while a
// stalled result word still sits in the output register. The output register
// lets the next frame run while a result waits. Write the registers while idle.
`timescale 1ns / 1ps

module stereo_width_smoothed import swsm_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [SAMPLE_BITS-1:0] left_in,
	input  logic signed [SAMPLE_BITS-1:0] right_in,
	input  logic                          block_end,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [SAMPLE_BITS-1:0] left_out,
	output logic signed [SAMPLE_BITS-1:0] right_out,
	output logic                          clipped,
	input  logic                          cfg_we,
	input  logic        [CFG_IDX_W-1:0]   cfg_index,
	input  logic        [CFG_W-1:0]       cfg_data
);

	state_t state_q, state_d;

	logic [CFG_W-1:0]  target_q;
	logic [COEF_W-1:0] coef_q;
	logic [GAIN_W-1:0] gain_q;
	logic [GAIN_W-1:0] t_q;

	logic signed [MUL_A_W-1:0] diff_q;
	logic signed [DLR_W-1:0]   dlr_q;
	logic signed [DLR_W-1:0]   sum_q;
	logic                      end_q;

	logic signed [PROD_W-1:0] prod_q;
	mul_ctrl_t                mul_ctrl;

	logic                   in_fire;
	logic                   out_free;
	logic                   gain_load;
	logic                   mix_fire;
	logic [CFG_W-1:0]       tq;
	logic [GAIN_W-1:0]      t_new;

	logic signed [PROD_W-1:0]  step_full;
	logic signed [PROD_W-1:0]  side_full;
	logic signed [MIX_W-1:0]   side_s;
	logic signed [MIX_W-1:0]   lsum;
	logic signed [MIX_W-1:0]   rsum;
	logic signed [MIX_W-1:0]   lrnd;
	logic signed [MIX_W-1:0]   rrnd;
	logic signed [SAMPLE_BITS-1:0] lsat;
	logic signed [SAMPLE_BITS-1:0] rsat;
	logic                      lclip;
	logic                      rclip;
	logic signed [MUL_A_W-1:0] snap_d;
	logic                      snap;

	logic                          out_valid_q;
	logic signed [SAMPLE_BITS-1:0] left_out_q;
	logic signed [SAMPLE_BITS-1:0] right_out_q;
	logic                          clipped_q;

	assign in_fire  = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= TARGET_RESET;
			coef_q   <= COEF_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SIDE_TARGET:    target_q <= cfg_data;
				REG_SMOOTHING_COEF: coef_q   <= COEF_W'(cfg_data);
				default: ;
			endcase
		end
	end

	assign tq    = (target_q > TARGET_MAX) ? TARGET_MAX : target_q;
	assign t_new = {tq, 16'd0};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_STEP;
			ST_STEP: state_d = ST_GAIN;
			ST_GAIN: state_d = ST_SIDE;
			ST_SIDE: state_d = ST_MIX;
			ST_MIX:  if (out_free) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall      = 1'b1;
		mul_ctrl.en   = 1'b0;
		mul_ctrl.side = 1'b0;
		gain_load     = 1'b0;
		mix_fire      = 1'b0;
		case (state_q)
			ST_IDLE: in_stall = 1'b0;
			ST_STEP: mul_ctrl.en = 1'b1;
			ST_GAIN: gain_load = 1'b1;
			ST_SIDE: begin
				mul_ctrl.en   = 1'b1;
				mul_ctrl.side = 1'b1;
			end
			ST_MIX:  mix_fire = out_free;
			default: in_stall = 1'b1;
		endcase
	end

	// frame capture
	always_ff @(posedge clk) begin
		if (in_fire) begin
			t_q    <= t_new;
			diff_q <= $signed({1'b0, t_new}) - $signed({1'b0, gain_q});
			dlr_q  <= DLR_W'(left_in) - DLR_W'(right_in);
			sum_q  <= DLR_W'(left_in) + DLR_W'(right_in);
			end_q  <= block_end;
		end
	end

	swsm_mul u_mul (
		.clk    (clk),
		.ctrl   (mul_ctrl),
		.diff   (diff_q),
		.coef   (coef_q),
		.dlr    (dlr_q),
		.gain   (gain_q),
		.prod_q (prod_q)
	);

	// rounded step; result stays in 0..2^31 so wraparound add is exact
	assign step_full = (prod_q + HALF_STEP) >>> 16;

	assign side_full = (prod_q + HALF_SIDE) >>> 30;
	assign side_s    = side_full[MIX_W-1:0];
	assign lsum      = MIX_W'(sum_q) + side_s;
	assign rsum      = MIX_W'(sum_q) - side_s;
	assign lrnd      = (lsum + MIX_W'(1)) >>> 1;
	assign rrnd      = (rsum + MIX_W'(1)) >>> 1;

	always_comb begin
		lclip = 1'b1;
		rclip = 1'b1;
		if (lrnd > MIX_W'(SAT_MAX))
			lsat = SAT_MAX;
		else if (lrnd < MIX_W'(SAT_MIN))
			lsat = SAT_MIN;
		else begin
			lsat  = lrnd[SAMPLE_BITS-1:0];
			lclip = 1'b0;
		end
		if (rrnd > MIX_W'(SAT_MAX))
			rsat = SAT_MAX;
		else if (rrnd < MIX_W'(SAT_MIN))
			rsat = SAT_MIN;
		else begin
			rsat  = rrnd[SAMPLE_BITS-1:0];
			rclip = 1'b0;
		end
	end

	assign snap_d = $signed({1'b0, gain_q}) - $signed({1'b0, t_q});
	assign snap   = end_q && (snap_d > SNAP_LO) && (snap_d < SNAP_HI);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			gain_q <= GAIN_UNITY;
		else if (gain_load)
			gain_q <= gain_q + step_full[GAIN_W-1:0];
		else if (mix_fire && snap)
			gain_q <= t_q;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (mix_fire)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (mix_fire) begin
			left_out_q  <= lsat;
			right_out_q <= rsat;
			clipped_q   <= lclip || rclip;
		end
	end

	assign out_valid = out_valid_q;
	assign left_out  = left_out_q;
	assign right_out = right_out_q;
	assign clipped   = clipped_q;

endmodule

// ----- rtl/swsm_mul.sv -----
// Shared signed multiplier with operand select and registered product.
`timescale 1ns / 1ps

module swsm_mul import swsm_pkg::*; (
	input  logic                       clk,
	input  mul_ctrl_t                  ctrl,
	input  logic signed [MUL_A_W-1:0]  diff,
	input  logic        [COEF_W-1:0]   coef,
	input  logic signed [DLR_W-1:0]    dlr,
	input  logic        [GAIN_W-1:0]   gain,
	output logic signed [PROD_W-1:0]   prod_q
);

	logic signed [MUL_A_W-1:0] op_a;
	logic signed [MUL_B_W-1:0] op_b;

	// gain step: (target - gain) * coef; side: (L - R) * gain
	always_comb begin
		if (ctrl.side) begin
			op_a = $signed({1'b0, gain});
			op_b = MUL_B_W'(dlr);
		end else begin
			op_a = diff;
			op_b = MUL_B_W'($signed({1'b0, coef}));
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.en)
			prod_q <= op_a * op_b;
	end

endmodule

// ----- rtl/swsm_checker.sv -----
// Port-level checks of the stereo width block, bound to the top level.
`timescale 1ns / 1ps
`include "stereo_width_smoothed_macros.svh"

module swsm_checker import swsm_pkg::*; (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic signed [SAMPLE_BITS-1:0] left_out,
	input logic signed [SAMPLE_BITS-1:0] right_out,
	input logic                          clipped
);

	// a taken frame keeps the input side busy through its step, gain, side and mix states
	`SWSM_ASSERT_IMP(a_busy_after_take, in_valid && !in_stall, ##1 in_stall ##1 in_stall ##1 in_stall ##1 in_stall, "input not stalled while frame in work")

	// a clipped word has at least one channel at a rail
	`SWSM_ASSERT_IMP(a_clip_at_rail, out_valid && clipped, left_out == SAT_MAX || left_out == SAT_MIN || right_out == SAT_MAX || right_out == SAT_MIN, "clipped set with no saturated channel")

	// a stalled result word is held
	`SWSM_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(left_out) && $stable(right_out) && $stable(clipped), "stalled output word changed")

	// the output register fills only at the end of a frame, never right after a take
	`SWSM_ASSERT_NXT(a_no_early_word, in_valid && !in_stall && !out_valid, !out_valid, "result word appeared too early")

endmodule

bind stereo_width_smoothed swsm_checker u_swsm_checker (.*);

// ----- tb/testbench.sv -----
// Self-checking testbench for stereo_width_smoothed: directed table, then random stereo blocks.
`timescale 1ns / 1ps

module testbench;
	import swsm_pkg::*;

	localparam int     RESET_CYCLES  = 8;
	localparam int     CYCLE_LIMIT   = 400000;
	localparam int     SEGMENTS      = 8;
	localparam int     ITEMS_PER_SEG = 125;
	localparam int     TAIL_CYCLES   = 20;
	localparam int     MAX_REPORTS   = 40;
	localparam int     DIR_ROWS      = 28;
	localparam longint SNAP_WIN      = 1024;

	// indexes that decode to no register
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

	typedef enum logic {
		ROW_FRAME,
		ROW_CFG
	} row_kind_t;

	typedef struct {
		logic signed [SAMPLE_BITS-1:0] l;
		logic signed [SAMPLE_BITS-1:0] r;
		logic                          be;
		bit                            known;
		logic signed [SAMPLE_BITS-1:0] l_exp;
		logic signed [SAMPLE_BITS-1:0] r_exp;
		logic                          clip_exp;
	} frame_t;

	typedef struct {
		row_kind_t                     kind;
		logic        [CFG_IDX_W-1:0]   idx;
		logic        [CFG_W-1:0]       val;
		logic signed [SAMPLE_BITS-1:0] l;
		logic signed [SAMPLE_BITS-1:0] r;
		logic                          be;
		bit                            known;
		logic signed [SAMPLE_BITS-1:0] l_exp;
		logic signed [SAMPLE_BITS-1:0] r_exp;
		logic                          clip_exp;
	} stim_row_t;

	typedef struct {
		logic signed [SAMPLE_BITS-1:0] l;
		logic signed [SAMPLE_BITS-1:0] r;
		logic                          clip;
	} result_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_stall;
	logic signed [SAMPLE_BITS-1:0] left_in = '0;
	logic signed [SAMPLE_BITS-1:0] right_in = '0;
	logic                          block_end = 1'b0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	logic signed [SAMPLE_BITS-1:0] left_out;
	logic signed [SAMPLE_BITS-1:0] right_out;
	logic                          clipped;
	logic                          cfg_we = 1'b0;
	logic        [CFG_IDX_W-1:0]   cfg_index = '0;
	logic        [CFG_W-1:0]       cfg_data = '0;

	// width model state
	logic [CFG_W-1:0]  tgt_reg = TARGET_RESET;
	logic [COEF_W-1:0] coef_reg = COEF_RESET;
	longint            side_gain = longint'(GAIN_UNITY);

	frame_t    frames_waiting[$];
	result_t   due_outputs[$];
	frame_t    on_bus;
	stim_row_t stim_tab[DIR_ROWS];

	int send_idle_pct = 0;
	int stall_pct = 0;
	int err_cnt = 0;
	int frames_taken = 0;
	int results_seen = 0;
	int clip_seen = 0;
	int snap_cnt = 0;
	int regs_written = 0;
	int cycle_cnt = 0;

	stereo_width_smoothed DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.left_in   (left_in),
		.right_in  (right_in),
		.block_end (block_end),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.left_out  (left_out),
		.right_out (right_out),
		.clipped   (clipped),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
				due_outputs.size());
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic signed [SAMPLE_BITS-1:0] clamp_sample(input longint x,
			inout bit hit);
		if (x > longint'(SAT_MAX)) begin
			hit = 1'b1;
			return SAT_MAX;
		end
		if (x < longint'(SAT_MIN)) begin
			hit = 1'b1;
			return SAT_MIN;
		end
		return SAMPLE_BITS'(x);
	endfunction

	// one frame: step the gain, mix mid/side, then snap on a block end
	function automatic result_t apply_width(input logic signed [SAMPLE_BITS-1:0] l,
			input logic signed [SAMPLE_BITS-1:0] r, input logic be);
		logic [CFG_W-1:0] tq;
		longint           t;
		longint           g;
		longint           s;
		longint           sum;
		longint           diff;
		bit               hit;
		result_t          res;
		tq = (tgt_reg > TARGET_MAX) ? TARGET_MAX : tgt_reg;
		t = longint'(tq) <<< 16;
		g = side_gain + ((((t - side_gain) * longint'(coef_reg))
			+ (longint'(1) <<< 15)) >>> 16);
		sum = longint'(l) + longint'(r);
		s = (((longint'(l) - longint'(r)) * g) + (longint'(1) <<< 29)) >>> 30;
		hit = 1'b0;
		res.l = clamp_sample((sum + s + 1) >>> 1, hit);
		res.r = clamp_sample((sum - s + 1) >>> 1, hit);
		res.clip = hit;
		diff = (g > t) ? g - t : t - g;
		if (be && diff < SNAP_WIN) begin
			if (g != t)
				snap_cnt++;
			g = t;
		end
		side_gain = g;
		return res;
	endfunction

	// sender: holds a stalled word, otherwise loads the next one or idles
	always @(posedge clk) begin : feed
		frame_t  nxt;
		result_t want;
		if (in_valid && !in_stall) begin
			want = apply_width(on_bus.l, on_bus.r, on_bus.be);
			if (on_bus.known) begin
				want.l = on_bus.l_exp;
				want.r = on_bus.r_exp;
				want.clip = on_bus.clip_exp;
			end
			due_outputs.push_back(want);
			frames_taken++;
		end
		if (!in_valid || !in_stall) begin
			if (frames_waiting.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				nxt = frames_waiting.pop_front();
				on_bus = nxt;
				in_valid <= 1'b1;
				left_in <= nxt.l;
				right_in <= nxt.r;
				block_end <= nxt.be;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	task automatic report_field(input string name, input longint want, input longint got);
		err_cnt++;
		if (err_cnt <= MAX_REPORTS)
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
	endtask

	always @(posedge clk) begin : check
		result_t e;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (clipped)
				clip_seen++;
			if (due_outputs.size() == 0) begin
				err_cnt++;
				if (err_cnt <= MAX_REPORTS)
					$display("%0t: unexpected word, expected none, got %0d %0d %0d", $time,
						left_out, right_out, clipped);
			end else begin
				e = due_outputs.pop_front();
				if (left_out !== e.l)
					report_field("left_out", e.l, left_out);
				if (right_out !== e.r)
					report_field("right_out", e.r, right_out);
				if (clipped !== e.clip)
					report_field("clipped", e.clip, clipped);
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SIDE_TARGET: tgt_reg = val;
			REG_SMOOTHING_COEF: coef_reg = val;
			default: ;
		endcase
		regs_written++;
	endtask

	task automatic drain();
		while (frames_waiting.size() != 0 || in_valid || due_outputs.size() != 0)
			@(posedge clk);
	endtask

	task automatic queue_frame(input logic signed [SAMPLE_BITS-1:0] l,
			input logic signed [SAMPLE_BITS-1:0] r, input logic be);
		frame_t f;
		f.l = l;
		f.r = r;
		f.be = be;
		f.known = 1'b0;
		f.l_exp = '0;
		f.r_exp = '0;
		f.clip_exp = 1'b0;
		frames_waiting.push_back(f);
	endtask

	function automatic logic signed [SAMPLE_BITS-1:0] pick_sample();
		case ($urandom_range(9))
			0: return SAT_MAX;
			1: return SAT_MIN;
			2: return SAMPLE_BITS'(int'($urandom_range(2000)) - 1000);
			default: return SAMPLE_BITS'($urandom());
		endcase
	endfunction

	function automatic logic [CFG_W-1:0] pick_target();
		case ($urandom_range(5))
			0: return '0;
			1: return TARGET_RESET;
			2: return TARGET_MAX;
			3: return 16'hFFFF;
			4: return CFG_W'($urandom_range(32769, 65535));
			default: return CFG_W'($urandom_range(32768));
		endcase
	endfunction

	function automatic logic [COEF_W-1:0] pick_coef();
		case ($urandom_range(5))
			0: return '0;
			1: return COEF_W'(1);
			2: return 16'hFFFF;
			3: return COEF_W'($urandom_range(8192, 256));
			default: return COEF_W'($urandom());
		endcase
	endfunction

	initial begin
		int     queued;
		int     blk_len;
		frame_t f;

		// kind, index, data, left, right, block end, typed, left/right/clip expected
		stim_tab = '{
			'{ROW_FRAME, '0, '0, '0, '0, 1'b0, 1'b1, '0, '0, 1'b0},
			'{ROW_FRAME, '0, '0, SAT_MAX, SAT_MAX, 1'b0, 1'b1, SAT_MAX, SAT_MAX, 1'b0},
			'{ROW_FRAME, '0, '0, SAT_MIN, SAT_MIN, 1'b0, 1'b1, SAT_MIN, SAT_MIN, 1'b0},
			'{ROW_FRAME, '0, '0, SAT_MAX, SAT_MIN, 1'b0, 1'b1, SAT_MAX, SAT_MIN, 1'b0},
			'{ROW_FRAME, '0, '0, SAT_MIN, SAT_MAX, 1'b1, 1'b1, SAT_MIN, SAT_MAX, 1'b0},
			'{ROW_FRAME, '0, '0, -24'sd1, 24'sd1, 1'b0, 1'b1, -24'sd1, 24'sd1, 1'b0},
			'{ROW_FRAME, '0, '0, 24'h555555, 24'hAAAAAA, 1'b0, 1'b1,
				24'h555555, 24'hAAAAAA, 1'b0},
			'{ROW_CFG, REG_SPARE_A, 16'hFFFF, '0, '0, 1'b0, 1'b0, '0, '0, 1'b0},
			'{ROW_CFG, REG_SPARE_B, 16'h0000, '0, '0, 1'b0, 1'b0, '0, '0, 1'b0},
			// spare writes must leave unity gain in place
			'{ROW_FRAME, '0, '0, 24'sd123, -24'sd456, 1'b1, 1'b1, 24'sd123, -24'sd456, 1'b0},
			'{ROW_CFG, REG_SIDE_TARGET, 16'hFFFF, '0, '0, 1'b0, 1'b0, '0, '0, 1'b0},
			'{ROW_CFG, REG_SMOOTHING_COEF, 16'hFFFF, '0, '0, 1'b0, 1'b0, '0, '0, 1'b0},
			'{ROW_FRAME, '0, '0, SAT_MAX, SAT_MIN, 1'b1, 1'b0, '0, '0, 1'b0},
			'{ROW_FRAME, '0, '0, SAT_MIN, SAT_MAX, 1'b1, 1'b0, '0, '0, 1'b0},
			'{ROW_FRAME, '0, '0, SAT_MAX, SAT_MIN, 1'b0, 1'b0, '0, '0, 1'b0},
			'{ROW_FRAME, '0, '0, SAT_MAX, SAT_MAX, 1'b0, 1'b0, '0, '0, 1'b0},
			'{ROW_CFG, REG_SIDE_TARGET, 16'h0000, '0, '0, 1'b0, 1'b0, '0, '0, 1'b0},
			'{ROW_FRAME, '0, '0, SAT_MAX, SAT_MIN, 1'b1, 1'b0, '0, '0, 1'b0},
			'{ROW_FRAME, '0, '0, 24'sd1, -24'sd1, 1'b1, 1'b0, '0, '0, 1'b0},
			// zero coefficient: gain parked away from the target
			'{ROW_CFG, REG_SIDE_TARGET, TARGET_MAX, '0, '0, 1'b0, 1'b0, '0, '0, 1'b0},
			'{ROW_CFG, REG_SMOOTHING_COEF, 16'h0000, '0, '0, 1'b0, 1'b0, '0, '0, 1'b0},
			'{ROW_FRAME, '0, '0, SAT_MIN, SAT_MAX, 1'b1, 1'b0, '0, '0, 1'b0},
			'{ROW_FRAME, '0, '0, 24'sd1000, -24'sd1000, 1'b1, 1'b0, '0, '0, 1'b0},
			'{ROW_CFG, REG_SMOOTHING_COEF, 16'h0001, '0, '0, 1'b0, 1'b0, '0, '0, 1'b0},
			'{ROW_FRAME, '0, '0, SAT_MAX, SAT_MIN, 1'b1, 1'b0, '0, '0, 1'b0},
			'{ROW_CFG, REG_SIDE_TARGET, TARGET_RESET, '0, '0, 1'b0, 1'b0, '0, '0, 1'b0},
			'{ROW_CFG, REG_SMOOTHING_COEF, COEF_RESET, '0, '0, 1'b0, 1'b0, '0, '0, 1'b0},
			'{ROW_FRAME, '0, '0, 24'sd4096, -24'sd4096, 1'b1, 1'b0, '0, '0, 1'b0}
		};

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 19;
		stall_pct = 19;
		foreach (stim_tab[i]) begin
			if (stim_tab[i].kind == ROW_CFG) begin
				drain();
				write_reg(stim_tab[i].idx, stim_tab[i].val);
			end else begin
				f.l = stim_tab[i].l;
				f.r = stim_tab[i].r;
				f.be = stim_tab[i].be;
				f.known = stim_tab[i].known;
				f.l_exp = stim_tab[i].l_exp;
				f.r_exp = stim_tab[i].r_exp;
				f.clip_exp = stim_tab[i].clip_exp;
				frames_waiting.push_back(f);
			end
		end

		for (int seg = 0; seg < SEGMENTS; seg++) begin
			drain();
			case (seg)
				0: begin
					write_reg(REG_SIDE_TARGET, TARGET_MAX);
					write_reg(REG_SMOOTHING_COEF, 16'hFFFF);
				end
				1: begin
					write_reg(REG_SIDE_TARGET, '0);
					write_reg(REG_SMOOTHING_COEF, 16'hFFFF);
				end
				default: begin
					write_reg(REG_SIDE_TARGET, pick_target());
					write_reg(REG_SMOOTHING_COEF, pick_coef());
				end
			endcase
			if ($urandom_range(2) == 0)
				write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, CFG_W'($urandom()));
			case (seg % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 73;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 73;
				end
				default: begin
					send_idle_pct = 19;
					stall_pct = 19;
				end
			endcase
			// mostly whole blocks closed by block_end, some loose frames
			queued = 0;
			while (queued < ITEMS_PER_SEG) begin
				if ($urandom_range(9) != 0) begin
					blk_len = $urandom_range(12, 1);
					for (int k = 0; k < blk_len; k++)
						queue_frame(pick_sample(), pick_sample(), k == blk_len - 1);
					queued += blk_len;
				end else begin
					queue_frame(pick_sample(), pick_sample(), 1'($urandom_range(1)));
					queued++;
				end
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("Ran %0d frames, %0d results, %0d register writes over %0d settings",
			frames_taken, results_seen, regs_written, SEGMENTS + 5);
		$display("%0d results clipped, %0d gain snaps at block end, %0d mismatches",
			clip_seen, snap_cnt, err_cnt);
		if (err_cnt == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/swsm_pkg.sv
rtl/swsm_mul.sv
rtl/stereo_width_smoothed.sv
rtl/swsm_checker.sv
tb/testbench.sv
